// ===== hw/rtl/ipg_pkg.sv =====
// shared constants and types for the integer partition generator
`default_nettype none

package ipg_pkg;

  localparam int MaxParts = 20;
  localparam int PartW    = 5;
  localparam int IdxW     = $clog2(MaxParts);
  localparam int CntW     = $clog2(MaxParts + 1);
  localparam int AddrW    = 3;
  localparam int DataW    = 32;

  localparam logic RegTarget = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FILL_INIT,
    OP_FILL,
    OP_ADV_INIT,
    OP_ADV_TAIL,
    OP_LOAD_CUR,
    OP_SCAN,
    OP_RAISE,
    OP_ONES,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic count_le1;
    logic fill_last;
    logic p_zero;
    logic p_one;
    logic cur_lt_prev;
    logic ones_zero;
    logic ones_one;
    logic emit_done;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ipg_dp.sv =====
// datapath: part store, scan registers, output register and target register
`default_nettype none

module ipg_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ipg_pkg::cmd_t                cmd_i,
  output ipg_pkg::status_t             status_o,
  input  logic                         cfg_we_i,
  input  logic [ipg_pkg::PartW-1:0]    cfg_target_i,
  output logic [ipg_pkg::PartW-1:0]    target_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [ipg_pkg::PartW-1:0]    part_o,
  output logic                         last_part_o,
  output logic                         final_partition_o
);

  localparam int PartW = ipg_pkg::PartW;
  localparam int IdxW  = ipg_pkg::IdxW;
  localparam int CntW  = ipg_pkg::CntW;

  logic [PartW-1:0] mem [ipg_pkg::MaxParts];
  logic [PartW-1:0] rdata_q;

  logic [PartW-1:0] target_q, target_d;
  logic             started_q, started_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  widx_q, widx_d;
  logic [PartW-1:0] tail_q, tail_d;
  logic [PartW-1:0] cur_q, cur_d;
  logic [IdxW-1:0]  p_q, p_d;
  logic [CntW-1:0]  ones_q, ones_d;
  logic [CntW-1:0]  k_q, k_d;
  logic             pend_q, pend_d;
  logic             pend_last_q, pend_last_d;
  logic             out_valid_q, out_valid_d;
  logic [PartW-1:0] part_q, part_d;
  logic             last_q, last_d;
  logic             final_q, final_d;

  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [PartW-1:0] mem_wdata;
  logic             mem_re;
  logic [IdxW-1:0]  mem_raddr;

  logic [CntW-1:0]  eff_t;
  logic [CntW-1:0]  cnt_m1, cnt_m2;
  logic [IdxW-1:0]  p_m1, p_m2;
  logic             load;

  always_comb begin
    if (target_q == '0) begin
      eff_t = CntW'(1);
    end else if (int'(target_q) > ipg_pkg::MaxParts) begin
      eff_t = CntW'(ipg_pkg::MaxParts);
    end else begin
      eff_t = CntW'(target_q);
    end
  end

  assign cnt_m1 = count_q - CntW'(1);
  assign cnt_m2 = count_q - CntW'(2);
  assign p_m1   = p_q - IdxW'(1);
  assign p_m2   = p_q - IdxW'(2);
  assign load   = pend_q && (!out_valid_q || out_ready_i);

  always_comb begin
    target_d    = target_q;
    started_d   = started_q;
    count_d     = count_q;
    widx_d      = widx_q;
    tail_d      = tail_q;
    cur_d       = cur_q;
    p_d         = p_q;
    ones_d      = ones_q;
    k_d         = k_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q;
    part_d      = part_q;
    last_d      = last_q;
    final_d     = final_q;
    mem_we      = 1'b0;
    mem_waddr   = widx_q[IdxW-1:0];
    mem_wdata   = PartW'(1);
    mem_re      = 1'b0;
    mem_raddr   = k_q[IdxW-1:0];

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (cmd_i.op)
      ipg_pkg::OP_FILL_INIT: begin
        widx_d    = '0;
        count_d   = eff_t;
        started_d = 1'b1;
        k_d       = '0;
        pend_d    = 1'b0;
      end
      ipg_pkg::OP_FILL: begin
        mem_we = 1'b1;
        widx_d = widx_q + CntW'(1);
      end
      ipg_pkg::OP_ADV_INIT: begin
        started_d = 1'b1;
        k_d       = '0;
        pend_d    = 1'b0;
        mem_re    = 1'b1;
        mem_raddr = cnt_m1[IdxW-1:0];
      end
      ipg_pkg::OP_ADV_TAIL: begin
        tail_d    = rdata_q;
        p_d       = cnt_m2[IdxW-1:0];
        mem_re    = 1'b1;
        mem_raddr = cnt_m2[IdxW-1:0];
      end
      ipg_pkg::OP_LOAD_CUR: begin
        cur_d = rdata_q;
        if (p_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = p_m1;
        end
      end
      ipg_pkg::OP_SCAN: begin
        if (!(cur_q < rdata_q)) begin
          tail_d = tail_q + cur_q;
          p_d    = p_m1;
          cur_d  = rdata_q;
          if (p_q != IdxW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = p_m2;
          end
        end
      end
      ipg_pkg::OP_RAISE: begin
        mem_we    = 1'b1;
        mem_waddr = p_q;
        mem_wdata = cur_q + PartW'(1);
        widx_d    = CntW'(p_q) + CntW'(1);
        ones_d    = CntW'(tail_q) - CntW'(1);
        count_d   = CntW'(p_q) + CntW'(tail_q);
      end
      ipg_pkg::OP_ONES: begin
        mem_we = 1'b1;
        widx_d = widx_q + CntW'(1);
        ones_d = ones_q - CntW'(1);
      end
      ipg_pkg::OP_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          part_d      = rdata_q;
          last_d      = pend_last_q;
          final_d     = (count_q == CntW'(1));
          pend_d      = 1'b0;
        end
        if ((k_q < count_q) && (!pend_q || load)) begin
          mem_re      = 1'b1;
          mem_raddr   = k_q[IdxW-1:0];
          pend_d      = 1'b1;
          pend_last_d = ((k_q + CntW'(1)) == count_q);
          k_d         = k_q + CntW'(1);
        end
      end
      default: begin
      end
    endcase

    if (cfg_we_i) begin
      target_d  = cfg_target_i;
      started_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= PartW'(1);
      started_q   <= 1'b0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      target_q    <= target_d;
      started_q   <= started_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    widx_q      <= widx_d;
    tail_q      <= tail_d;
    cur_q       <= cur_d;
    p_q         <= p_d;
    ones_q      <= ones_d;
    k_q         <= k_d;
    pend_last_q <= pend_last_d;
    part_q      <= part_d;
    last_q      <= last_d;
    final_q     <= final_d;
  end

  assign status_o.started     = started_q;
  assign status_o.count_le1   = (count_q <= CntW'(1));
  assign status_o.fill_last   = (widx_q == cnt_m1);
  assign status_o.p_zero      = (p_q == '0);
  assign status_o.p_one       = (p_q == IdxW'(1));
  assign status_o.cur_lt_prev = (cur_q < rdata_q);
  assign status_o.ones_zero   = (ones_q == '0);
  assign status_o.ones_one    = (ones_q == CntW'(1));
  assign status_o.emit_done   = (k_q == count_q) && !pend_q;

  assign target_o          = target_q;
  assign out_valid_o       = out_valid_q;
  assign part_o            = part_q;
  assign last_part_o       = last_q;
  assign final_partition_o = final_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ipg_ctrl.sv =====
// controller state machine sequencing fill, advance scan and part emission
`default_nettype none

module ipg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             restart_i,
  output logic             in_ready_o,
  input  ipg_pkg::status_t status_i,
  output ipg_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StFill    = 3'd1;
  localparam logic [2:0] StAdvTail = 3'd2;
  localparam logic [2:0] StLoadCur = 3'd3;
  localparam logic [2:0] StScan    = 3'd4;
  localparam logic [2:0] StRaise   = 3'd5;
  localparam logic [2:0] StOnes    = 3'd6;
  localparam logic [2:0] StEmit    = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = ipg_pkg::OP_NONE;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (restart_i || !status_i.started || status_i.count_le1) begin
            cmd_o.op = ipg_pkg::OP_FILL_INIT;
            state_d  = StFill;
          end else begin
            cmd_o.op = ipg_pkg::OP_ADV_INIT;
            state_d  = StAdvTail;
          end
        end
      end
      StFill: begin
        cmd_o.op = ipg_pkg::OP_FILL;
        if (status_i.fill_last) begin
          state_d = StEmit;
        end
      end
      StAdvTail: begin
        cmd_o.op = ipg_pkg::OP_ADV_TAIL;
        state_d  = StLoadCur;
      end
      StLoadCur: begin
        cmd_o.op = ipg_pkg::OP_LOAD_CUR;
        state_d  = status_i.p_zero ? StRaise : StScan;
      end
      StScan: begin
        cmd_o.op = ipg_pkg::OP_SCAN;
        if (status_i.cur_lt_prev || status_i.p_one) begin
          state_d = StRaise;
        end
      end
      StRaise: begin
        cmd_o.op = ipg_pkg::OP_RAISE;
        state_d  = StOnes;
      end
      StOnes: begin
        if (status_i.ones_zero) begin
          state_d = StEmit;
        end else begin
          cmd_o.op = ipg_pkg::OP_ONES;
          if (status_i.ones_one) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        cmd_o.op = ipg_pkg::OP_EMIT;
        if (status_i.emit_done) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/integer_partition_generator.sv =====
// top level of the integer partition generator
//
// usage: write target_number at byte address 0 of the apb port, then send
// request items on the in channel (restart_i = 1 starts again at all ones,
// 0 asks for the next partition). each request yields one out item per part,
// largest part first; last_part_o marks the final part of a partition and
// final_partition_o is set on every part of the single-part partition.
// after the single-part partition the next request wraps to all ones.
// sequence: a fresh start writes t ones; an advance scans right to left,
// raises one part and writes the ones after it, all bound by the single
// write port of the part store. emission then streams one part per cycle
// while out_ready_i is high, from the store's registered read port.
// a new request is taken only once the previous one has handed all parts
// to the output register; the last part may still wait there meanwhile.
// when out_ready_i is low, emission pauses and nothing is lost.
// reset: target 1, next request starts at all ones; a target write also
// forces the next request to start at all ones.
`default_nettype none

module integer_partition_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         restart_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ipg_pkg::PartW-1:0]    part_o,
  output logic                         last_part_o,
  output logic                         final_partition_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ipg_pkg::AddrW-1:0]    paddr,
  input  logic [ipg_pkg::DataW-1:0]    pwdata,
  output logic [ipg_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  ipg_pkg::cmd_t                 cmd;
  ipg_pkg::status_t              status;
  logic                          cfg_we;
  logic [ipg_pkg::PartW-1:0]     target;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == ipg_pkg::RegTarget);
  assign prdata = (paddr[2] == ipg_pkg::RegTarget) ? ipg_pkg::DataW'(target) : '0;

  ipg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ipg_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we),
    .cfg_target_i      (pwdata[ipg_pkg::PartW-1:0]),
    .target_o          (target),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .part_o            (part_o),
    .last_part_o       (last_part_o),
    .final_partition_o (final_partition_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/integer_partition_generator_tb.sv =====
// testbench for the integer partition generator: directed table, random phases, self-check
`timescale 1ns / 1ps

module integer_partition_generator_tb;
  import ipg_pkg::*;

  localparam logic [AddrW-1:0] TargetAddr   = {RegTarget, 2'b00};
  localparam logic [AddrW-1:0] UnmappedAddr = {~RegTarget, 2'b00};
  localparam int RandomItems = 140;
  localparam int CalmItems   = 30;
  localparam int DrainCycles = 80;
  localparam int NumRows     = 26;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [AddrW-1:0] addr;
    logic [31:0]      data;
    logic             restart;
    logic [PartW-1:0] lead;
    logic [PartW-1:0] count;
  } plan_row_t;

  typedef struct packed {
    logic [PartW-1:0] part;
    logic             last_part;
    logic             final_partition;
  } part_item_t;

  // lead = 0 means the row is checked against the predictor
  localparam plan_row_t Plan [NumRows] = '{
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd1, 5'd1},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd1, 5'd1},
    '{ROW_CFG, TargetAddr,   32'd2,          1'b0, 5'd0, 5'd0},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd1, 5'd2},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd2, 5'd1},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd1, 5'd2},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b1, 5'd1, 5'd2},
    '{ROW_CFG, TargetAddr,   32'd0,          1'b0, 5'd0, 5'd0},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b1, 5'd1, 5'd1},
    '{ROW_CFG, TargetAddr,   32'hFFFF_FFE6,  1'b0, 5'd0, 5'd0},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd1, 5'd6},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd0, 5'd0},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd0, 5'd0},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd0, 5'd0},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd0, 5'd0},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd0, 5'd0},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b1, 5'd1, 5'd6},
    '{ROW_CFG, UnmappedAddr, 32'd3,          1'b0, 5'd0, 5'd0},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd0, 5'd0},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd0, 5'd0},
    '{ROW_CFG, TargetAddr,   32'd31,         1'b0, 5'd0, 5'd0},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd1, 5'd20},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b0, 5'd0, 5'd0},
    '{ROW_CFG, TargetAddr,   32'd20,         1'b0, 5'd0, 5'd0},
    '{ROW_REQ, TargetAddr,   32'd0,          1'b1, 5'd1, 5'd20},
    '{ROW_CFG, TargetAddr,   32'hA5A5_A5F5,  1'b0, 5'd0, 5'd0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             restart_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [PartW-1:0] part_o;
  logic             last_part_o;
  logic             final_partition_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic [PartW-1:0] pred_target;
  logic [PartW-1:0] pred_store [MaxParts];
  int               pred_count;
  bit               pred_started;
  part_item_t       part_q [$];
  int               mismatches;
  bit               calm;
  bit               quiet;

  integer_partition_generator DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .restart_i         (restart_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .part_o            (part_o),
    .last_part_o       (last_part_o),
    .final_partition_o (final_partition_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int target_parts();
    int t;
    t = int'(pred_target);
    if (t < 1) t = 1;
    if (t > MaxParts) t = MaxParts;
    return t;
  endfunction

  function automatic void fill_ones();
    int t;
    t = target_parts();
    for (int k = 0; k < t; k++) pred_store[k] = PartW'(1);
    pred_count = t;
  endfunction

  // next partition: raise the rightmost part that can grow, tail becomes ones
  function automatic void step_partition(bit rs);
    int  p;
    int  tail;
    int  k;
    bit  found;
    if (rs || !pred_started || pred_count <= 1 || pred_count > MaxParts) begin
      fill_ones();
    end else begin
      p = pred_count - 1;
      tail = int'(pred_store[p]);
      found = 1'b0;
      while (p > 0 && !found) begin
        p--;
        if (tail >= 1 && (p == 0 || int'(pred_store[p]) + 1 <= int'(pred_store[p - 1]))) begin
          pred_store[p] = pred_store[p] + PartW'(1);
          k = 0;
          while (k + 1 < tail && p + 1 + k < MaxParts) begin
            pred_store[p + 1 + k] = PartW'(1);
            k++;
          end
          pred_count = p + 1 + k;
          found = 1'b1;
        end else begin
          tail += int'(pred_store[p]);
        end
      end
      if (!found) fill_ones();
    end
    pred_started = 1'b1;
  endfunction

  function automatic void queue_predicted();
    for (int k = 0; k < pred_count; k++)
      part_q.push_back('{pred_store[k], k + 1 == pred_count, pred_count == 1});
  endfunction

  function automatic void queue_uniform(logic [PartW-1:0] lead, int cnt);
    for (int k = 0; k < cnt; k++)
      part_q.push_back('{lead, k + 1 == cnt, cnt == 1});
  endfunction

  task automatic issue_request(input bit rs);
    if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (part_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [AddrW-1:0] a, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (a == TargetAddr) begin
      pred_target  = d[PartW-1:0];
      pred_started = 1'b0;
    end
  endtask

  initial begin : out_pacing
    int hold;
    hold = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        hold = $urandom_range(0, 13);
      end else begin
        out_ready_i <= 1'b1;
        hold = $urandom_range(0, 9);
      end
    end
  end

  always @(posedge clk_i) begin : check_parts
    part_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (part_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: part %0d last %0b final %0b",
                   part_o, last_part_o, final_partition_o);
      end else begin
        want = part_q.pop_front();
        if (part_o !== want.part || last_part_o !== want.last_part ||
            final_partition_o !== want.final_partition) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected part %0d last %0b final %0b, got %0d %0b %0b",
                     want.part, want.last_part, want.final_partition,
                     part_o, last_part_o, final_partition_o);
        end
      end
    end
  end

  initial begin : stimulus
    int          sent;
    int          n;
    int          t;
    logic [31:0] d;
    bit          rs;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    restart_i    <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    pred_target  = PartW'(1);
    pred_count   = 0;
    pred_started = 1'b0;
    mismatches   = 0;
    calm         = 1'b0;
    quiet        = 1'b0;
    sent         = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Plan[i]) begin
      if (Plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(Plan[i].addr, Plan[i].data);
      end else begin
        issue_request(Plan[i].restart);
        step_partition(Plan[i].restart);
        if (Plan[i].lead != 0) queue_uniform(Plan[i].lead, int'(Plan[i].count));
        else queue_predicted();
      end
    end

    while (sent < RandomItems) begin
      wait_idle();
      quiet = ($urandom_range(0, 3) == 0);
      d = $urandom;
      if ($urandom_range(0, 9) == 0)
        d[PartW-1:0] = ($urandom_range(0, 1) == 0) ? 5'd0 : PartW'($urandom_range(20, 31));
      else
        d[PartW-1:0] = PartW'($urandom_range(1, 8));
      if ($urandom_range(0, 7) == 0) write_reg(UnmappedAddr, d);
      else write_reg(TargetAddr, d);
      t = target_parts();
      n = (t >= 12) ? $urandom_range(3, 10) : $urandom_range(5, 30);
      for (int k = 0; k < n && sent < RandomItems; k++) begin
        calm = (sent >= RandomItems - CalmItems);
        rs = ($urandom_range(0, 11) == 0);
        issue_request(rs);
        step_partition(rs);
        queue_predicted();
        sent++;
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
